### sv/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// Linear concatenation request splitter package
// Shared constants, codes and the structures that travel along the cell row.
// ----------------------------------------------------------------------------
package lcrs_pkg;

   // Member table depth and the number of members that can be active at once.
   localparam int MAX_MEMBERS  = 8;
   localparam int ACTIVE_LIMIT = (MAX_MEMBERS < 8) ? MAX_MEMBERS : 8;
   localparam int NUM_CELLS    = ACTIVE_LIMIT;

   // Fixed field widths.
   localparam int IDX_W     = 3;
   localparam int COUNT_W   = 4;
   localparam int SECT_W    = 39;
   localparam int SECT_SH   = 9;                  // 512-byte sectors
   localparam int BYTE_W    = SECT_W + SECT_SH;   // 48
   localparam int OFF_W     = 48;
   localparam int PHYS_W    = 49;
   localparam int LEN_W     = 32;

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MEMBER_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] MEMBER_COUNT_RESET = COUNT_W'(1);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK     = 1'b0,
      STATUS_BEYOND = 1'b1
   } status_type;

   // Write of one member table entry.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [SECT_W-1:0] size;
      logic [SECT_W-1:0] start;
   } load_type;

   // Request context handed from cell to cell.
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] rem;
      logic             wr;
   } token_type;

   // One result item; all fields are zero when valid is low.
   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  disk;
      logic [PHYS_W-1:0] phys;
      logic [LEN_W-1:0]  len;
      logic              wr;
      logic              status;
      logic              last;
   } result_type;

endpackage

### sv/linear_concat_request_splitter.sv
// ----------------------------------------------------------------------------
// Linear concatenation request splitter
// Maps a logical byte range of a concatenated array onto member disk pieces.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                     Moves
//   --------  ----------------------------  -----------------------------------
//   request   start & !busy                 table load or request, req_* ports
//   result    rsp_valid (one cycle)         one piece or error, rsp_* ports
//   config    psel & penable & pwrite       member_count at byte address 0
//
// A request transfer enters the first cell of a row of eight cells, each of
// which holds one member table entry. The request context moves one cell per
// cycle, so a request holds busy while it visits the members in turn: at least
// one cell, up to the active member count, eight at most. Each result appears
// in the cycle after its cell has processed the context. A table load never
// raises busy. Reset is synchronous and sets member_count to one; the member
// table itself is not cleared. The result receiver cannot stall, so every
// piece is presented for exactly one cycle.
module linear_concat_request_splitter (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [lcrs_pkg::IDX_W-1:0]    req_member_index,
   input  logic [lcrs_pkg::SECT_W-1:0]   req_member_size_sectors,
   input  logic [lcrs_pkg::SECT_W-1:0]   req_member_start_sectors,
   input  logic [lcrs_pkg::OFF_W-1:0]    req_offset_bytes,
   input  logic [lcrs_pkg::LEN_W-1:0]    req_length_bytes,
   input  logic                          req_is_write,
   // Result channel.
   output logic                          rsp_valid,
   output logic [lcrs_pkg::IDX_W-1:0]    rsp_disk_index,
   output logic [lcrs_pkg::PHYS_W-1:0]   rsp_physical_offset_bytes,
   output logic [lcrs_pkg::LEN_W-1:0]    rsp_piece_length,
   output logic                          rsp_piece_is_write,
   output logic                          rsp_status,
   output logic                          rsp_last,
   // Configuration port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lcrs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lcrs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lcrs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);
   import lcrs_pkg::*;

   logic [COUNT_W-1:0] member_count_ff;
   logic [COUNT_W-1:0] active_count;
   logic               accept;
   logic               csr_write;
   load_type           load;
   token_type          tok_link [NUM_CELLS+1];
   result_type         cell_result [NUM_CELLS];
   logic [NUM_CELLS-1:0] cell_holding;
   result_type         result_any;

   logic               rsp_valid_ff;
   result_type         rsp_ff;

   // ------------------------------------------------------------------------
   // Configuration register. Register index is the byte address over four.
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[CSR_ADDR_W-1] == CSR_IDX_MEMBER_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         member_count_ff <= MEMBER_COUNT_RESET;
      end else if (csr_write) begin
         member_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == CSR_IDX_MEMBER_COUNT) begin
         prdata = {(CSR_DATA_W-COUNT_W)'(0), member_count_ff};
      end
   end

   // Counts above the table depth behave as the full table.
   assign active_count = (member_count_ff > COUNT_W'(ACTIVE_LIMIT)) ?
                         COUNT_W'(ACTIVE_LIMIT) : member_count_ff;

   // ------------------------------------------------------------------------
   // Request intake. A load writes one cell's entry; a request becomes the
   // context token that enters the first cell.
   // ------------------------------------------------------------------------
   assign accept = start && !busy;
   assign busy   = |cell_holding;

   always_comb begin
      load.en    = accept && (req_op == OP_LOAD) &&
                   ({1'b0, req_member_index} < (IDX_W+1)'(MAX_MEMBERS));
      load.index = req_member_index;
      load.size  = req_member_size_sectors;
      load.start = req_member_start_sectors;

      tok_link[0].valid = accept && (req_op == OP_REQUEST);
      tok_link[0].found = 1'b0;
      tok_link[0].off   = req_offset_bytes;
      tok_link[0].rem   = req_length_bytes;
      tok_link[0].wr    = req_is_write;
   end

   // ------------------------------------------------------------------------
   // Cell row. Only one cell holds a live token at any time.
   // ------------------------------------------------------------------------
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      lcrs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IDX_W'(c)),
         .active_count (active_count),
         .load         (load),
         .tok_in       (tok_link[c]),
         .tok_out      (tok_link[c+1]),
         .result       (cell_result[c]),
         .holding      (cell_holding[c])
      );
   end

   // The last cell always finishes the token, so its hand-off stays idle.
   always_comb begin
      result_any = '0;
      for (int c = 0; c < NUM_CELLS; c++) begin
         result_any = result_any | cell_result[c];
      end
   end

   // ------------------------------------------------------------------------
   // Result register: each piece is shown for one cycle.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result_any.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= result_any;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_disk_index            = rsp_ff.disk;
   assign rsp_physical_offset_bytes = rsp_ff.phys;
   assign rsp_piece_length          = rsp_ff.len;
   assign rsp_piece_is_write        = rsp_ff.wr;
   assign rsp_status                = rsp_ff.status;
   assign rsp_last                  = rsp_ff.last;

endmodule

### sv/lcrs_cell.sv
// ----------------------------------------------------------------------------
// Splitter cell
// Holds one member table entry and processes the request token for one cycle.
// ----------------------------------------------------------------------------
module lcrs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lcrs_pkg::IDX_W-1:0] cell_index,
   input  logic [lcrs_pkg::COUNT_W-1:0] active_count,
   input  lcrs_pkg::load_type         load,
   input  lcrs_pkg::token_type        tok_in,
   output lcrs_pkg::token_type        tok_out,
   output lcrs_pkg::result_type       result,
   output logic                       holding
);
   import lcrs_pkg::*;

   logic [SECT_W-1:0] size_ff;
   logic [SECT_W-1:0] start_ff;
   token_type         tok_ff;

   logic [BYTE_W-1:0] size_bytes;
   logic [BYTE_W-1:0] start_bytes;
   logic [OFF_W:0]    diff;
   logic              below;
   logic              hit;
   logic              in_range;
   logic              last_active;
   logic [OFF_W-1:0]  room;
   logic [LEN_W-1:0]  piece;
   logic [LEN_W-1:0]  rem_next;
   logic              done;

   // Table entry; contents are undefined until loaded.
   always_ff @(posedge clock) begin
      if (load.en && load.index == cell_index) begin
         size_ff  <= load.size;
         start_ff <= load.start;
      end
   end

   // Only the valid bit of the token is reset; the context follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.found <= tok_in.found;
      tok_ff.off   <= tok_in.off;
      tok_ff.rem   <= tok_in.rem;
      tok_ff.wr    <= tok_in.wr;
   end

   assign holding = tok_ff.valid;

   always_comb begin
      size_bytes  = {size_ff, SECT_SH'(0)};
      start_bytes = {start_ff, SECT_SH'(0)};
      diff        = {1'b0, tok_ff.off} - {1'b0, size_bytes};
      below       = diff[OFF_W];
      hit         = tok_ff.found || below;
      in_range    = {1'b0, cell_index} < active_count;
      last_active = ({1'b0, cell_index} + COUNT_W'(1)) >= active_count;
      room        = size_bytes - tok_ff.off;
      piece       = ({(OFF_W-LEN_W)'(0), tok_ff.rem} < room) ? tok_ff.rem : room[LEN_W-1:0];
      rem_next    = tok_ff.rem - piece;
      done        = (rem_next == '0) || last_active;

      tok_out = '0;
      result  = '0;
      if (tok_ff.valid) begin
         if (!in_range) begin
            result.valid  = 1'b1;
            result.status = STATUS_BEYOND;
            result.last   = 1'b1;
         end else if (hit) begin
            result.valid  = 1'b1;
            result.disk   = cell_index;
            result.phys   = {1'b0, start_bytes} + {1'b0, tok_ff.off};
            result.len    = piece;
            result.wr     = tok_ff.wr;
            result.status = STATUS_OK;
            result.last   = done;
            if (!done) begin
               tok_out.valid = 1'b1;
               tok_out.found = 1'b1;
               tok_out.off   = '0;
               tok_out.rem   = rem_next;
               tok_out.wr    = tok_ff.wr;
            end
         end else if (last_active) begin
            result.valid  = 1'b1;
            result.status = STATUS_BEYOND;
            result.last   = 1'b1;
         end else begin
            tok_out.valid = 1'b1;
            tok_out.found = 1'b0;
            tok_out.off   = diff[OFF_W-1:0];
            tok_out.rem   = tok_ff.rem;
            tok_out.wr    = tok_ff.wr;
         end
      end
   end

endmodule

### sv/lcrs_checker.sv
// ----------------------------------------------------------------------------
// Splitter port checker
// Watches the top-level ports for request and result sequencing rules.
// ----------------------------------------------------------------------------
module lcrs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_op,
   input  logic                          rsp_valid,
   input  logic [lcrs_pkg::IDX_W-1:0]    rsp_disk_index,
   input  logic [lcrs_pkg::PHYS_W-1:0]   rsp_physical_offset_bytes,
   input  logic [lcrs_pkg::LEN_W-1:0]    rsp_piece_length,
   input  logic                          rsp_status,
   input  logic                          rsp_last
);
   import lcrs_pkg::*;

   // An accepted request occupies the cell row in the next cycle.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_REQUEST) |=> busy)
      else $error("request transfer did not raise busy");

   // An error result always closes its request.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BEYOND) |-> rsp_last)
      else $error("error result without last");

   // An error result carries no piece.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BEYOND) |->
      (rsp_disk_index == '0) && (rsp_piece_length == '0) &&
      (rsp_physical_offset_bytes == '0))
      else $error("error result with nonzero piece fields");

   // Every result comes from a token that was in the row in the previous cycle.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // A piece that is not last leaves the request still in the row.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("request ended before its last piece");

endmodule

bind linear_concat_request_splitter lcrs_checker u_lcrs_checker (.*);
